### rtl/assert_macros.svh
// Assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication failed");

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

### rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] PAD_WORD = 32'h80000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} sha_state_t;

	// source of the next word pushed into the block buffer
	typedef enum logic [1:0] {
		SRC_INPUT,
		SRC_MARKER,
		SRC_ZERO,
		SRC_LENGTH
	} word_src_t;

	typedef struct packed {
		logic      push;
		word_src_t src;
		logic      load_rounds;
		logic      do_round;
		logic      fold;
		logic      finish;
		logic      out_load;
	} sha_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic [3:0] fill;
		logic       round_last;
		logic       marker_due;
		logic       len_lo_due;
	} sha_status_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

### rtl/sha_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [2:0]  valid_bytes;
	logic        end_of_message;
	modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
	modport sink (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_digest_word;
	modport source (output valid, digest_word, word_index, last_digest_word, input ready);
	modport sink (input valid, digest_word, word_index, last_digest_word, output ready);
endinterface

### rtl/sha_datapath.sv
`timescale 1ns / 1ps
module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sha_cmd_t    cmd,
	input  logic [31:0] in_word,
	input  logic [2:0]  in_bytes,
	input  logic        in_last,
	input  logic [2:0]  out_idx,
	output sha_status_t status,
	output logic [31:0] out_word
);

	logic [31:0] block_q [16];
	logic [31:0] win_q [16];
	logic [31:0] var_q [8];
	logic [31:0] chain_q [8];
	logic [3:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] len_q;
	logic        len_hi_q;
	logic        marker_q;
	logic [2:0]  nb;
	logic [31:0] keep;
	logic [31:0] push_val;
	logic [31:0] w, w2, w15, s0, s1, wn, t1, t2;
	logic [31:0] a, b, c, e, f, g;

	// clamp byte count, build masked word (with its marker if short) and pick the pushed value
	always_comb begin
		nb = in_last ? ((in_bytes > 3'd4) ? 3'd4 : in_bytes) : 3'd4;
		case (nb)
			3'd0: keep = 32'h80000000;
			3'd1: keep = (in_word & 32'hff000000) | 32'h00800000;
			3'd2: keep = (in_word & 32'hffff0000) | 32'h00008000;
			3'd3: keep = (in_word & 32'hffffff00) | 32'h00000080;
			default: keep = in_word;
		endcase
		case (cmd.src)
			SRC_INPUT:  push_val = keep;
			SRC_MARKER: push_val = PAD_WORD;
			SRC_ZERO:   push_val = '0;
			SRC_LENGTH: push_val = len_hi_q ? len_q[63:32] : len_q[31:0];
			default:    push_val = '0;
		endcase
	end

	// round logic on the sliding window
	always_comb begin
		a = var_q[0]; b = var_q[1]; c = var_q[2];
		e = var_q[4]; f = var_q[5]; g = var_q[6];
		w2  = win_q[14];
		w15 = win_q[1];
		s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		wn = s1 + win_q[9] + s0 + win_q[0];
		w = win_q[0];
		t1 = var_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & f) ^ (~e & g)) + ROUND_K[round_q] + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
	end

	// advance fill and round counters, marker flag and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			len_q    <= '0;
			len_hi_q <= 1'b1;
			marker_q <= 1'b0;
			round_q  <= '0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 4'd1;
				if (cmd.src == SRC_INPUT) begin
					len_q <= len_q + {58'd0, nb, 3'd0};
					marker_q <= in_last && (nb == 3'd4);
				end else if (cmd.src == SRC_MARKER) begin
					marker_q <= 1'b0;
				end
				if (cmd.src == SRC_LENGTH)
					len_hi_q <= ~len_hi_q;
			end
			if (cmd.load_rounds)
				round_q <= '0;
			else if (cmd.do_round)
				round_q <= round_q + 6'd1;
			if (cmd.finish) begin
				len_q    <= '0;
				len_hi_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			block_q[fill_q] <= push_val;
		if (cmd.load_rounds) begin
			// the sixteenth word is written on this edge, so take it directly
			for (int i = 0; i < 15; i++) win_q[i] <= block_q[i];
			win_q[15] <= push_val;
			for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
		end else if (cmd.do_round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
			win_q[15] <= wn;
			var_q[7] <= g; var_q[6] <= f; var_q[5] <= e; var_q[4] <= var_q[3] + t1;
			var_q[3] <= c; var_q[2] <= b; var_q[1] <= a; var_q[0] <= t1 + t2;
		end
	end

	// hold chaining value; fold after rounds, restore after digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
		end else if (cmd.finish) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
		end
	end

	assign out_word          = chain_q[out_idx];
	assign status.block_full = (fill_q == 4'd15);
	assign status.fill       = fill_q;
	assign status.round_last = (round_q == 6'd63);
	assign status.marker_due = marker_q;
	assign status.len_lo_due = !len_hi_q;

endmodule

### rtl/sha_ctrl.sv
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  out_idx,
	input  sha_status_t status,
	output sha_cmd_t    cmd
);

	sha_state_t state_q, state_d;
	logic       padding_q;
	logic       len_stage_q;
	logic [2:0] idx_q;
	logic       in_fire;

	assign in_fire = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) begin
				if (status.block_full) state_d = ST_ROUND;
				else if (in_last) state_d = ST_PAD;
			end
			ST_ROUND: if (status.round_last) state_d = ST_FOLD;
			ST_FOLD: begin
				if (len_stage_q) state_d = ST_EMIT;
				else if (padding_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: if (status.block_full) state_d = ST_ROUND;
			ST_EMIT: if (out_ready && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.src = SRC_INPUT;
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		case (state_q)
			ST_IDLE: begin
				cmd.push = in_fire;
				cmd.load_rounds = in_fire && status.block_full;
			end
			ST_ROUND: cmd.do_round = 1'b1;
			ST_FOLD: cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.push = 1'b1;
				// marker first, then the length in the last two slots of a block
				if (status.marker_due) cmd.src = SRC_MARKER;
				else if (status.fill == 4'd14) cmd.src = SRC_LENGTH;
				else if (status.fill == 4'd15 && status.len_lo_due) cmd.src = SRC_LENGTH;
				else cmd.src = SRC_ZERO;
				cmd.load_rounds = status.block_full;
			end
			ST_EMIT: cmd.finish = out_ready && idx_q == 3'd7;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			padding_q   <= 1'b0;
			len_stage_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			// track the padding phase: set when the closing word is taken
			if (state_q == ST_IDLE && in_fire && in_last) padding_q <= 1'b1;
			if (state_q == ST_PAD && cmd.src == SRC_LENGTH && status.fill == 4'd15)
				len_stage_q <= 1'b1;
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					padding_q <= 1'b0;
					len_stage_q <= 1'b0;
				end
			end
		end
	end

	assign out_idx = idx_q;

endmodule

### rtl/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 hasher.
// Input channel: one big-endian 32-bit message word per handshake; the word
// with end_of_message set closes the message and may hold 0 to 4 bytes.
// Output channel: eight digest words, word_index 0 to 7, last_digest_word on
// the eighth, after which the block starts a fresh message.
// Throughput: one word is taken per cycle while the block is idle; each
// sixteenth word starts a loop of 64 rounds on the round unit and then a
// fold, and no input is taken until the fold is done.
// After the final word: padding pushes one word per cycle up to the next
// block end, then each remaining block (one or two) runs its rounds and fold,
// then the digest words go out at one per cycle while the receiver is ready.
// Reset clears the controller, counters and length and loads the initial
// hash value; buffer contents are undefined until written.
// A stalled receiver holds the current digest word; no input is taken
// until all eight words are delivered.
module sha256_message_hasher import sha_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	sha_in_if.sink   in_ch,
	sha_out_if.source out_ch
);

	sha_cmd_t    cmd;
	sha_status_t status;
	logic [2:0]  idx;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.end_of_message), .in_ready(in_ch.ready),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_idx(idx),
		.status(status), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_word(in_ch.message_word), .in_bytes(in_ch.valid_bytes),
		.in_last(in_ch.end_of_message), .out_idx(idx),
		.status(status), .out_word(out_ch.digest_word)
	);

	assign out_ch.word_index       = idx;
	assign out_ch.last_digest_word = (idx == 3'd7);

endmodule

### rtl/sha_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_index,
	input logic       last_digest_word
);
	`ASSERT_IMPLY(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`ASSERT_IMPLY(a_last_flag, clk, arst_n, out_valid, last_digest_word == (word_index == 3'd7))
	`ASSERT_NEXT(a_index_step, clk, arst_n, out_valid && out_ready && word_index != 3'd7, out_valid && word_index == $past(word_index) + 3'd1)
	`ASSERT_NEXT(a_done_idle, clk, arst_n, out_valid && out_ready && last_digest_word, !out_valid && in_ready)
endmodule

bind sha256_message_hasher sha_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .word_index(out_ch.word_index),
	.last_digest_word(out_ch.last_digest_word)
);
